// ===== hw/rtl/speed_mode_hysteresis_fsm_assert.svh =====
// Assertion macros shared by the speed mode hysteresis RTL.
`ifndef SPEED_MODE_HYSTERESIS_FSM_ASSERT_SVH
`define SPEED_MODE_HYSTERESIS_FSM_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SMH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("speed mode hysteresis: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("speed mode hysteresis: next-cycle check failed");

`endif

// ===== hw/rtl/smh_pkg.sv =====
// Package with types, constants and helpers of the speed mode hysteresis block.
`default_nettype none

package smh_pkg;

   // Field widths.
   localparam int STAMP_WIDTH = 32;
   localparam int SPEED_WIDTH = 16;
   localparam int MODE_WIDTH  = 3;
   localparam int HOLD_WIDTH  = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int CSR_IDX_WIDTH = 3;

   // Width that holds ten times a speed and three times the bridge speed.
   localparam int CMP_WIDTH = (SPEED_WIDTH + 4 > HOLD_WIDTH + 4) ?
                              SPEED_WIDTH + 4 : HOLD_WIDTH + 4;

   // Mode codes; codes above OTHER behave like OTHER.
   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NORMAL   = 3'd0,
      MODE_CAUTIOUS = 3'd1,
      MODE_BRAKE    = 3'd2,
      MODE_RECOVER  = 3'd3,
      MODE_OTHER    = 3'd4
   } mode_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_DDP_ENABLE      = 3'd0,
      CSR_BRIDGE_SPEED    = 3'd1,
      CSR_START_GRACE     = 3'd2,
      CSR_DOWN_HOLD       = 3'd3,
      CSR_UP_HOLD         = 3'd4,
      CSR_STOP_HOLD       = 3'd5,
      CSR_RECOVER_HOLD    = 3'd6
   } csr_index_type;

   // Register values after reset.
   localparam logic [HOLD_WIDTH-1:0] RST_BRIDGE_SPEED = 16'd1000;
   localparam logic [HOLD_WIDTH-1:0] RST_START_GRACE  = 16'd1000;
   localparam logic [HOLD_WIDTH-1:0] RST_DOWN_HOLD    = 16'd1500;
   localparam logic [HOLD_WIDTH-1:0] RST_UP_HOLD      = 16'd1500;
   localparam logic [HOLD_WIDTH-1:0] RST_STOP_HOLD    = 16'd2000;
   localparam logic [HOLD_WIDTH-1:0] RST_RECOVER_HOLD = 16'd1000;

   // Configuration seen by the decision logic.
   typedef struct packed {
      logic                  ddp_enable;
      logic [HOLD_WIDTH-1:0] bridge_speed_mmps;
      logic [HOLD_WIDTH-1:0] start_grace_ms;
      logic [HOLD_WIDTH-1:0] down_hold_ms;
      logic [HOLD_WIDTH-1:0] up_hold_ms;
      logic [HOLD_WIDTH-1:0] stop_hold_ms;
      logic [HOLD_WIDTH-1:0] recover_hold_ms;
   } cfg_type;

   // One speed sample.
   typedef struct packed {
      logic [SPEED_WIDTH-1:0] speed_mmps;
      logic [STAMP_WIDTH-1:0] stamp_ms;
      logic                   goal_received;
      logic                   goal_reached;
      logic [MODE_WIDTH-1:0]  cur_mode;
   } req_item_type;

   // One mode decision.
   typedef struct packed {
      logic                  mode_change;
      logic [MODE_WIDTH-1:0] next_mode;
      logic                  recover_exit;
   } rsp_item_type;

   // Time since a start stamp, modulo the stamp width.
   function automatic logic [STAMP_WIDTH-1:0] elapsed(
      input logic [STAMP_WIDTH-1:0] now,
      input logic [STAMP_WIDTH-1:0] start
   );
      return now - start;
   endfunction

   // Hold register widened to the stamp width.
   function automatic logic [STAMP_WIDTH-1:0] hold_ext(input logic [HOLD_WIDTH-1:0] hold);
      return STAMP_WIDTH'(hold);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smh_channels.sv =====
// Valid/ready channel interfaces for speed samples and mode decisions.
`default_nettype none

interface smh_req_if import smh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SPEED_WIDTH-1:0] speed_mmps;
   logic [STAMP_WIDTH-1:0] stamp_ms;
   logic                   goal_received;
   logic                   goal_reached;
   logic [MODE_WIDTH-1:0]  cur_mode;

   modport source (output valid, speed_mmps, stamp_ms, goal_received, goal_reached,
                   cur_mode, input ready);
   modport sink   (input valid, speed_mmps, stamp_ms, goal_received, goal_reached,
                   cur_mode, output ready);
endinterface

interface smh_rsp_if import smh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  mode_change;
   logic [MODE_WIDTH-1:0] next_mode;
   logic                  recover_exit;

   modport source (output valid, mode_change, next_mode, recover_exit, input ready);
   modport sink   (input valid, mode_change, next_mode, recover_exit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smh_csr.sv =====
// Configuration register file of the speed mode hysteresis block.
`default_nettype none

module smh_csr
   import smh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [CSR_IDX_WIDTH-1:0] index,
   input  wire logic [CSR_WIDTH-1:0]     wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;

   // Register writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ddp_enable        <= 1'b1;
         cfg_ff.bridge_speed_mmps <= RST_BRIDGE_SPEED;
         cfg_ff.start_grace_ms    <= RST_START_GRACE;
         cfg_ff.down_hold_ms      <= RST_DOWN_HOLD;
         cfg_ff.up_hold_ms        <= RST_UP_HOLD;
         cfg_ff.stop_hold_ms      <= RST_STOP_HOLD;
         cfg_ff.recover_hold_ms   <= RST_RECOVER_HOLD;
      end else if (wr_en) begin
         case (index)
            CSR_DDP_ENABLE:   cfg_ff.ddp_enable        <= wdata[0];
            CSR_BRIDGE_SPEED: cfg_ff.bridge_speed_mmps <= wdata[HOLD_WIDTH-1:0];
            CSR_START_GRACE:  cfg_ff.start_grace_ms    <= wdata[HOLD_WIDTH-1:0];
            CSR_DOWN_HOLD:    cfg_ff.down_hold_ms      <= wdata[HOLD_WIDTH-1:0];
            CSR_UP_HOLD:      cfg_ff.up_hold_ms        <= wdata[HOLD_WIDTH-1:0];
            CSR_STOP_HOLD:    cfg_ff.stop_hold_ms      <= wdata[HOLD_WIDTH-1:0];
            CSR_RECOVER_HOLD: cfg_ff.recover_hold_ms   <= wdata[HOLD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/smh_eval.sv =====
// Hysteresis timers and the mode decision for one registered speed sample.
`default_nettype none
`include "speed_mode_hysteresis_fsm_assert.svh"

module smh_eval
   import smh_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   input  wire logic   fire,
   input  wire req_item_type item,
   output rsp_item_type rsp
);

   logic [MODE_WIDTH-1:0]  prev_mode_ff, prev_mode_in;
   logic [STAMP_WIDTH-1:0] normal_entry_ff, normal_entry_in;
   logic [STAMP_WIDTH-1:0] down_start_ff, down_start_in;
   logic [STAMP_WIDTH-1:0] up_start_ff, up_start_in;
   logic [STAMP_WIDTH-1:0] stop_start_ff, stop_start_in;
   logic [STAMP_WIDTH-1:0] moving_start_ff, moving_start_in;
   logic                   down_armed_ff, down_armed_in;
   logic                   up_armed_ff, up_armed_in;
   logic                   stop_armed_ff, stop_armed_in;
   logic                   moving_armed_ff, moving_armed_in;

   logic [CMP_WIDTH-1:0]   speed_x4;
   logic [CMP_WIDTH-1:0]   speed_x10;
   logic [CMP_WIDTH-1:0]   bridge_x1;
   logic [CMP_WIDTH-1:0]   bridge_x3;
   logic                   below_quarter;
   logic                   at_or_above_30pct;
   logic                   below_tenth;
   logic                   entering_normal;
   logic                   down_armed_now;
   logic [STAMP_WIDTH-1:0] entry_now;
   logic                   grace_active;
   logic                   no_goal;
   logic [MODE_WIDTH-1:0]  next_mode;
   logic                   recover_exit;
   logic [MODE_WIDTH+3:0]  ctl_state;
   logic                   any_hold_armed;
   logic                   exit_ok;

   // Exact threshold compares: constant multiples built from shifts and adds.
   assign speed_x4  = CMP_WIDTH'(item.speed_mmps) << 2;
   assign speed_x10 = (CMP_WIDTH'(item.speed_mmps) << 3) + (CMP_WIDTH'(item.speed_mmps) << 1);
   assign bridge_x1 = CMP_WIDTH'(cfg.bridge_speed_mmps);
   assign bridge_x3 = (bridge_x1 << 1) + bridge_x1;

   assign below_quarter     = speed_x4 < bridge_x1;
   assign at_or_above_30pct = speed_x10 >= bridge_x3;
   assign below_tenth       = speed_x10 < bridge_x1;

   // A goal that is missing or already reached leaves the machine tracking only.
   assign no_goal = !item.goal_received || item.goal_reached;

   // Entering NORMAL restarts the grace window and drops the down timer.
   assign entering_normal = (item.cur_mode == MODE_NORMAL) && (prev_mode_ff != MODE_NORMAL);
   assign down_armed_now  = down_armed_ff && !entering_normal;
   assign entry_now       = entering_normal ? item.stamp_ms : normal_entry_ff;
   assign grace_active = elapsed(item.stamp_ms, entry_now) < hold_ext(cfg.start_grace_ms);

   // Next state and decision for the sample.
   always_comb begin
      prev_mode_in    = prev_mode_ff;
      normal_entry_in = normal_entry_ff;
      down_start_in   = down_start_ff;
      up_start_in     = up_start_ff;
      stop_start_in   = stop_start_ff;
      moving_start_in = moving_start_ff;
      down_armed_in   = down_armed_ff;
      up_armed_in     = up_armed_ff;
      stop_armed_in   = stop_armed_ff;
      moving_armed_in = moving_armed_ff;
      next_mode       = item.cur_mode;
      recover_exit    = 1'b0;

      if (cfg.ddp_enable) begin
         prev_mode_in = item.cur_mode;
         if (no_goal) begin
            down_armed_in = 1'b0;
            up_armed_in   = 1'b0;
            stop_armed_in = 1'b0;
         end else begin
            normal_entry_in = entry_now;
            case (item.cur_mode)
               MODE_NORMAL: begin
                  up_armed_in   = 1'b0;
                  stop_armed_in = 1'b0;
                  down_armed_in = 1'b0;
                  if (!grace_active && below_quarter) begin
                     if (!down_armed_now) begin
                        down_start_in = item.stamp_ms;
                        down_armed_in = 1'b1;
                     end else if (elapsed(item.stamp_ms, down_start_ff) >=
                                  hold_ext(cfg.down_hold_ms)) begin
                        next_mode = MODE_CAUTIOUS;
                     end else begin
                        down_armed_in = 1'b1;
                     end
                  end
               end
               MODE_CAUTIOUS: begin
                  down_armed_in = 1'b0;
                  up_armed_in   = 1'b0;
                  stop_armed_in = 1'b0;
                  if (at_or_above_30pct) begin
                     if (!up_armed_ff) begin
                        up_start_in = item.stamp_ms;
                        up_armed_in = 1'b1;
                     end else if (elapsed(item.stamp_ms, up_start_ff) >=
                                  hold_ext(cfg.up_hold_ms)) begin
                        next_mode = MODE_NORMAL;
                     end else begin
                        up_armed_in = 1'b1;
                     end
                  end
                  if (below_tenth) begin
                     if (!stop_armed_ff) begin
                        stop_start_in = item.stamp_ms;
                        stop_armed_in = 1'b1;
                     end else if (elapsed(item.stamp_ms, stop_start_ff) >
                                  hold_ext(cfg.stop_hold_ms)) begin
                        next_mode = MODE_BRAKE;
                     end else begin
                        stop_armed_in = 1'b1;
                     end
                  end
               end
               MODE_RECOVER: begin
                  down_armed_in   = 1'b0;
                  up_armed_in     = 1'b0;
                  stop_armed_in   = 1'b0;
                  moving_armed_in = 1'b0;
                  if (!below_tenth) begin
                     if (!moving_armed_ff) begin
                        moving_start_in = item.stamp_ms;
                        moving_armed_in = 1'b1;
                     end else if (elapsed(item.stamp_ms, moving_start_ff) >=
                                  hold_ext(cfg.recover_hold_ms)) begin
                        next_mode    = MODE_CAUTIOUS;
                        recover_exit = 1'b1;
                     end else begin
                        moving_armed_in = 1'b1;
                     end
                  end
               end
               default: begin
                  // Brake, other and unused codes: every timer stands down.
                  down_armed_in   = 1'b0;
                  up_armed_in     = 1'b0;
                  stop_armed_in   = 1'b0;
                  moving_armed_in = 1'b0;
               end
            endcase
         end
      end

      rsp.mode_change  = next_mode != item.cur_mode;
      rsp.next_mode    = next_mode;
      rsp.recover_exit = recover_exit;
   end

   // Control state: armed flags and the last seen mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mode_ff    <= MODE_OTHER;
         down_armed_ff   <= 1'b0;
         up_armed_ff     <= 1'b0;
         stop_armed_ff   <= 1'b0;
         moving_armed_ff <= 1'b0;
      end else if (fire) begin
         prev_mode_ff    <= prev_mode_in;
         down_armed_ff   <= down_armed_in;
         up_armed_ff     <= up_armed_in;
         stop_armed_ff   <= stop_armed_in;
         moving_armed_ff <= moving_armed_in;
      end
   end

   // Timer start stamps.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_entry_ff <= '0;
         down_start_ff   <= '0;
         up_start_ff     <= '0;
         stop_start_ff   <= '0;
         moving_start_ff <= '0;
      end else if (fire) begin
         normal_entry_ff <= normal_entry_in;
         down_start_ff   <= down_start_in;
         up_start_ff     <= up_start_in;
         stop_start_ff   <= stop_start_in;
         moving_start_ff <= moving_start_in;
      end
   end

   // Short names for the checked conditions.
   assign ctl_state = {prev_mode_ff, down_armed_ff, up_armed_ff, stop_armed_ff, moving_armed_ff};
   assign any_hold_armed = down_armed_ff || up_armed_ff || stop_armed_ff;
   assign exit_ok = item.cur_mode == MODE_RECOVER && rsp.next_mode == MODE_CAUTIOUS &&
                    rsp.mode_change;

   // An exit from RECOVER always asks for CAUTIOUS.
   `SMH_ASSERT_IMPLY(a_exit_goes_cautious, clock, reset, fire && rsp.recover_exit, exit_ok)
   // A disabled block leaves its state alone.
   `SMH_ASSERT_NEXT(a_disabled_keeps_state, clock, reset, fire && !cfg.ddp_enable, $stable(ctl_state))
   // Without an active goal the three hold timers are disarmed.
   `SMH_ASSERT_NEXT(a_no_goal_disarms, clock, reset, fire && cfg.ddp_enable && no_goal, !any_hold_armed)

endmodule

`default_nettype wire

// ===== hw/rtl/speed_mode_hysteresis_fsm.sv =====
// Top level of the speed mode hysteresis block.
// Speed samples arrive as beats on the req_bus channel (valid/ready); each
// sample yields exactly one mode decision beat on the rsp_bus channel, in order.
// A sample is taken into an input register; once the result register is free
// or being emptied, the decision logic reads it together with the timer state,
// updates the state and loads the result register, which drives rsp_bus.
// Throughput is one sample per cycle while the receiver does not stall, set by
// the single decision pass between the input register and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register may still take one more sample; only when both are full is
// req_bus.ready low. Configuration registers are written through csr_wr_en,
// csr_index and csr_wdata; the user must write them only while no sample is in
// flight, and the block itself does not enforce this.
// A synchronous, active-high reset empties both registers, clears the timers
// and loads the register defaults; the block accepts a sample right after.
`default_nettype none
`include "speed_mode_hysteresis_fsm_assert.svh"

module speed_mode_hysteresis_fsm
   import smh_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   smh_req_if.sink                       req_bus,
   smh_rsp_if.source                     rsp_bus,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_WIDTH-1:0]     csr_wdata
);

   cfg_type      cfg;
   req_item_type req_item_ff;
   logic         req_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         rsp_valid_ff;
   logic         fire;
   logic         req_take;

   smh_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   // A sample is evaluated when the result register is free or being emptied.
   assign fire     = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !req_valid_ff || fire;

   // Input register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.speed_mmps    <= req_bus.speed_mmps;
         req_item_ff.stamp_ms      <= req_bus.stamp_ms;
         req_item_ff.goal_received <= req_bus.goal_received;
         req_item_ff.goal_reached  <= req_bus.goal_reached;
         req_item_ff.cur_mode      <= req_bus.cur_mode;
      end
   end

   smh_eval u_eval (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .fire  (fire),
      .item  (req_item_ff),
      .rsp   (rsp_item_in)
   );

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mode_change  = rsp_item_ff.mode_change;
   assign rsp_bus.next_mode    = rsp_item_ff.next_mode;
   assign rsp_bus.recover_exit = rsp_item_ff.recover_exit;

   // With both registers full and the receiver stalled, no sample is taken.
   `SMH_ASSERT_IMPLY(a_full_blocks_input, clock, reset, req_valid_ff && rsp_valid_ff && !rsp_bus.ready, !req_bus.ready && !fire)

endmodule

`default_nettype wire

// ===== verif/speed_mode_hysteresis_fsm_tb.sv =====
// Self-checking testbench for the speed mode hysteresis block with a predictor of its decisions.
`timescale 1ns / 100ps

module speed_mode_hysteresis_fsm_tb;
   import smh_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   // Speed bands relative to the thresholds of the current bridge speed.
   typedef enum int {
      BAND_STOP,
      BAND_CRAWL,
      BAND_MID,
      BAND_FAST,
      BAND_EDGE,
      BAND_ANY
   } speed_band_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_DDP_ENABLE;
   logic [CSR_WIDTH-1:0]     csr_wdata = '0;

   smh_req_if req_bus ();
   smh_rsp_if rsp_bus ();

   speed_mode_hysteresis_fsm u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Samples waiting to be sent and decisions waiting to be seen.
   req_item_type pending_samples[$];
   rsp_item_type due_decisions[$];
   req_item_type send_beat;
   req_item_type taken_beat;
   rsp_item_type oldest_due;

   int error_count   = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   logic [STAMP_WIDTH-1:0] stamp_cursor = '0;

   // Register copy used by the predictor.
   cfg_type live_cfg = '{
      ddp_enable:        1'b1,
      bridge_speed_mmps: RST_BRIDGE_SPEED,
      start_grace_ms:    RST_START_GRACE,
      down_hold_ms:      RST_DOWN_HOLD,
      up_hold_ms:        RST_UP_HOLD,
      stop_hold_ms:      RST_STOP_HOLD,
      recover_hold_ms:   RST_RECOVER_HOLD
   };

   // Timer state of the predictor, at its reset values.
   logic [MODE_WIDTH-1:0]  last_mode    = MODE_OTHER;
   logic [STAMP_WIDTH-1:0] normal_since = '0;
   logic [STAMP_WIDTH-1:0] down_since   = '0;
   logic [STAMP_WIDTH-1:0] up_since     = '0;
   logic [STAMP_WIDTH-1:0] stop_since   = '0;
   logic [STAMP_WIDTH-1:0] moving_since = '0;
   logic down_on   = 1'b0;
   logic up_on     = 1'b0;
   logic stop_on   = 1'b0;
   logic moving_on = 1'b0;

   always #5 clock = ~clock;

   // Works out the decision for one accepted sample and advances the timers.
   function automatic rsp_item_type decide_mode(input req_item_type s);
      rsp_item_type           r;
      logic [MODE_WIDTH-1:0]  nxt;
      logic                   ends_recover;
      logic [20:0]            spd4;
      logic [20:0]            spd10;
      logic [20:0]            brg;
      logic [20:0]            brg3;
      logic [STAMP_WIDTH-1:0] since_entry;
      logic [STAMP_WIDTH-1:0] since_down;
      logic [STAMP_WIDTH-1:0] since_up;
      logic [STAMP_WIDTH-1:0] since_stop;
      logic [STAMP_WIDTH-1:0] since_moving;
      nxt = s.cur_mode;
      ends_recover = 1'b0;
      spd4  = 21'(s.speed_mmps) * 21'd4;
      spd10 = 21'(s.speed_mmps) * 21'd10;
      brg   = 21'(live_cfg.bridge_speed_mmps);
      brg3  = brg * 21'd3;
      if (live_cfg.ddp_enable) begin
         if (!s.goal_received || s.goal_reached) begin
            // Without an active goal the mode is only tracked.
            down_on = 1'b0;
            up_on = 1'b0;
            stop_on = 1'b0;
            last_mode = s.cur_mode;
         end else begin
            if (s.cur_mode == MODE_NORMAL && last_mode != MODE_NORMAL) begin
               down_on = 1'b0;
               normal_since = s.stamp_ms;
            end
            last_mode = s.cur_mode;
            since_entry  = s.stamp_ms - normal_since;
            since_down   = s.stamp_ms - down_since;
            since_up     = s.stamp_ms - up_since;
            since_stop   = s.stamp_ms - stop_since;
            since_moving = s.stamp_ms - moving_since;
            if (s.cur_mode == MODE_NORMAL) begin
               // Low speed after the grace period drops to cautious.
               up_on = 1'b0;
               stop_on = 1'b0;
               if (since_entry >= live_cfg.start_grace_ms && spd4 < brg) begin
                  if (!down_on) begin
                     down_since = s.stamp_ms;
                     down_on = 1'b1;
                  end else if (since_down >= live_cfg.down_hold_ms) begin
                     nxt = MODE_CAUTIOUS;
                     down_on = 1'b0;
                  end
               end else begin
                  down_on = 1'b0;
               end
            end else if (s.cur_mode == MODE_CAUTIOUS) begin
               // Sustained speed returns to normal, sustained near-stop brakes.
               down_on = 1'b0;
               if (spd10 >= brg3) begin
                  if (!up_on) begin
                     up_since = s.stamp_ms;
                     up_on = 1'b1;
                  end else if (since_up >= live_cfg.up_hold_ms) begin
                     nxt = MODE_NORMAL;
                     up_on = 1'b0;
                  end
               end else begin
                  up_on = 1'b0;
               end
               if (spd10 < brg) begin
                  if (!stop_on) begin
                     stop_since = s.stamp_ms;
                     stop_on = 1'b1;
                  end else if (since_stop > live_cfg.stop_hold_ms) begin
                     nxt = MODE_BRAKE;
                     stop_on = 1'b0;
                  end
               end else begin
                  stop_on = 1'b0;
               end
            end else begin
               // Recover leaves on sustained motion; all other modes just disarm.
               down_on = 1'b0;
               up_on = 1'b0;
               stop_on = 1'b0;
               if (s.cur_mode == MODE_RECOVER && spd10 >= brg) begin
                  if (!moving_on) begin
                     moving_since = s.stamp_ms;
                     moving_on = 1'b1;
                  end else if (since_moving >= live_cfg.recover_hold_ms) begin
                     nxt = MODE_CAUTIOUS;
                     ends_recover = 1'b1;
                     moving_on = 1'b0;
                  end
               end else begin
                  moving_on = 1'b0;
               end
            end
         end
      end
      r.mode_change = (nxt != s.cur_mode);
      r.next_mode = nxt;
      r.recover_exit = ends_recover;
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ns: ERROR: %s", $time, msg);
      error_count++;
   endtask

   // Driver: one beat at a time from the pending queue, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            send_beat = pending_samples.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.speed_mmps    <= send_beat.speed_mmps;
            req_bus.stamp_ms      <= send_beat.stamp_ms;
            req_bus.goal_received <= send_beat.goal_received;
            req_bus.goal_reached  <= send_beat.goal_reached;
            req_bus.cur_mode      <= send_beat.cur_mode;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each sample beat, checks each decision beat, stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         if (req_bus.valid && req_bus.ready) begin
            taken_beat.speed_mmps    = req_bus.speed_mmps;
            taken_beat.stamp_ms      = req_bus.stamp_ms;
            taken_beat.goal_received = req_bus.goal_received;
            taken_beat.goal_reached  = req_bus.goal_reached;
            taken_beat.cur_mode      = req_bus.cur_mode;
            due_decisions.push_back(decide_mode(taken_beat));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_decisions.size() == 0) begin
               report_error($sformatf("decision beat with none due, next_mode %0d",
                                      rsp_bus.next_mode));
            end else begin
               oldest_due = due_decisions.pop_front();
               if (rsp_bus.mode_change !== oldest_due.mode_change)
                  report_error($sformatf("mode_change %0b, expected %0b",
                                         rsp_bus.mode_change, oldest_due.mode_change));
               if (rsp_bus.next_mode !== oldest_due.next_mode)
                  report_error($sformatf("next_mode %0d, expected %0d",
                                         rsp_bus.next_mode, oldest_due.next_mode));
               if (rsp_bus.recover_exit !== oldest_due.recover_exit)
                  report_error($sformatf("recover_exit %0b, expected %0b",
                                         rsp_bus.recover_exit, oldest_due.recover_exit));
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: too long without any beat ends the run.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void add_sample(input logic [SPEED_WIDTH-1:0] spd,
                                      input logic [STAMP_WIDTH-1:0] stamp,
                                      input logic rx, input logic done,
                                      input logic [MODE_WIDTH-1:0] mode);
      req_item_type s;
      s.speed_mmps = spd;
      s.stamp_ms = stamp;
      s.goal_received = rx;
      s.goal_reached = done;
      s.cur_mode = mode;
      pending_samples.push_back(s);
   endfunction

   // Picks a speed inside a band around the thresholds of bridge speed b.
   function automatic logic [SPEED_WIDTH-1:0] pick_speed(input speed_band_type band,
                                                         input int b);
      int stop_top;
      int down_lo;
      int up_lo;
      int lo;
      int hi;
      stop_top = (b == 0) ? 0 : (b - 1) / 10;
      down_lo = (b + 3) / 4;
      up_lo = (3 * b + 9) / 10;
      case (band)
         BAND_STOP: begin
            lo = 0;
            hi = stop_top;
         end
         BAND_CRAWL: begin
            lo = (b + 9) / 10;
            hi = down_lo - 1;
         end
         BAND_MID: begin
            lo = down_lo;
            hi = up_lo - 1;
         end
         BAND_FAST: begin
            lo = up_lo;
            hi = 65535;
         end
         BAND_EDGE: begin
            case ($urandom_range(5))
               0: lo = stop_top;
               1: lo = stop_top + 1;
               2: lo = down_lo - 1;
               3: lo = down_lo;
               4: lo = up_lo - 1;
               default: lo = up_lo;
            endcase
            hi = lo;
         end
         default: begin
            lo = 0;
            hi = 65535;
         end
      endcase
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (hi < lo) hi = lo;
      return SPEED_WIDTH'($urandom_range(hi, lo));
   endfunction

   // Segments of one mode with steadily advancing stamps, plus some noise.
   function automatic void add_random_samples(input int count);
      int made;
      int seg_len;
      int pick;
      int step_max;
      logic seg_goal_off;
      logic rx;
      logic done;
      logic [MODE_WIDTH-1:0] seg_mode;
      logic [MODE_WIDTH-1:0] mode;
      speed_band_type main_band;
      speed_band_type band;
      made = 0;
      step_max = int'(live_cfg.start_grace_ms);
      if (live_cfg.down_hold_ms > step_max) step_max = int'(live_cfg.down_hold_ms);
      if (live_cfg.up_hold_ms > step_max) step_max = int'(live_cfg.up_hold_ms);
      if (live_cfg.stop_hold_ms > step_max) step_max = int'(live_cfg.stop_hold_ms);
      if (live_cfg.recover_hold_ms > step_max) step_max = int'(live_cfg.recover_hold_ms);
      step_max = step_max / 3 + 2;
      while (made < count) begin
         seg_len = $urandom_range(12, 3);
         pick = $urandom_range(99);
         if (pick < 35) begin
            seg_mode = MODE_NORMAL;
            main_band = ($urandom_range(3) == 0) ? BAND_FAST
                        : speed_band_type'($urandom_range(1));
         end else if (pick < 70) begin
            seg_mode = MODE_CAUTIOUS;
            main_band = $urandom_range(1) ? BAND_FAST : BAND_STOP;
         end else if (pick < 88) begin
            seg_mode = MODE_RECOVER;
            main_band = speed_band_type'($urandom_range(3, 1));
         end else begin
            seg_mode = MODE_WIDTH'($urandom_range(7));
            main_band = speed_band_type'($urandom_range(5));
         end
         seg_goal_off = ($urandom_range(99) < 10);
         for (int k = 0; k < seg_len && made < count; k++) begin
            rx = 1'b1;
            done = 1'b0;
            mode = seg_mode;
            band = main_band;
            if (seg_goal_off) begin
               rx = 1'($urandom_range(1));
               done = rx ? 1'b1 : 1'($urandom_range(1));
            end
            if ($urandom_range(99) < 10) band = speed_band_type'($urandom_range(5));
            if ($urandom_range(99) < 3) begin
               rx = 1'($urandom_range(1));
               done = 1'($urandom_range(1));
            end
            if ($urandom_range(99) < 3) mode = MODE_WIDTH'($urandom_range(7));
            if ($urandom_range(99) < 3)
               stamp_cursor = $urandom();
            else
               stamp_cursor += STAMP_WIDTH'($urandom_range(step_max, 0));
            add_sample(pick_speed(band, int'(live_cfg.bridge_speed_mmps)), stamp_cursor, rx,
                       done, mode);
            made++;
         end
      end
   endfunction

   function automatic cfg_type moderate_settings();
      cfg_type c;
      c.ddp_enable        = 1'b1;
      c.bridge_speed_mmps = HOLD_WIDTH'($urandom_range(3000, 1));
      c.start_grace_ms    = HOLD_WIDTH'($urandom_range(2000, 0));
      c.down_hold_ms      = HOLD_WIDTH'($urandom_range(2500, 0));
      c.up_hold_ms        = HOLD_WIDTH'($urandom_range(2500, 0));
      c.stop_hold_ms      = HOLD_WIDTH'($urandom_range(2500, 0));
      c.recover_hold_ms   = HOLD_WIDTH'($urandom_range(2500, 0));
      return c;
   endfunction

   // Holds the sender until every due decision has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || due_decisions.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes all seven registers on back-to-back cycles.
   task automatic load_settings(input cfg_type c);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DDP_ENABLE;
      csr_wdata <= CSR_WIDTH'(c.ddp_enable);
      @(posedge clock);
      csr_index <= CSR_BRIDGE_SPEED;
      csr_wdata <= c.bridge_speed_mmps;
      @(posedge clock);
      csr_index <= CSR_START_GRACE;
      csr_wdata <= c.start_grace_ms;
      @(posedge clock);
      csr_index <= CSR_DOWN_HOLD;
      csr_wdata <= c.down_hold_ms;
      @(posedge clock);
      csr_index <= CSR_UP_HOLD;
      csr_wdata <= c.up_hold_ms;
      @(posedge clock);
      csr_index <= CSR_STOP_HOLD;
      csr_wdata <= c.stop_hold_ms;
      @(posedge clock);
      csr_index <= CSR_RECOVER_HOLD;
      csr_wdata <= c.recover_hold_ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      live_cfg = c;
   endtask

   task automatic run_phase(input cfg_type c, input int idle_pct, input int stall,
                            input int count);
      wait_drained();
      load_settings(c);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      add_random_samples(count);
   endtask

   // Main sequence: reset, directed samples, then random phases.
   initial begin
      cfg_type s;
      req_bus.valid = 1'b0;
      req_bus.speed_mmps = '0;
      req_bus.stamp_ms = '0;
      req_bus.goal_received = 1'b0;
      req_bus.goal_reached = 1'b0;
      req_bus.cur_mode = MODE_OTHER;
      rsp_bus.ready = 1'b0;

      // Directed walk through every transition with the reset settings.
      add_sample(16'd0,     32'd0,        1'b0, 1'b0, MODE_NORMAL);
      add_sample(16'hFFFF,  32'hFFFF_FFFF, 1'b1, 1'b1, MODE_CAUTIOUS);
      add_sample(16'd0,     32'd1000,     1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd0,     32'd1999,     1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd249,   32'd2000,     1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd0,     32'd3499,     1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd0,     32'd3500,     1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd300,   32'd3600,     1'b1, 1'b0, MODE_CAUTIOUS);
      add_sample(16'hFFFF,  32'd5100,     1'b1, 1'b0, MODE_CAUTIOUS);
      add_sample(16'd99,    32'd5200,     1'b1, 1'b0, MODE_CAUTIOUS);
      add_sample(16'd0,     32'd7200,     1'b1, 1'b0, MODE_CAUTIOUS);
      add_sample(16'd0,     32'd7201,     1'b1, 1'b0, MODE_CAUTIOUS);
      add_sample(16'd0,     32'd7300,     1'b1, 1'b0, MODE_BRAKE);
      add_sample(16'd100,   32'd7400,     1'b1, 1'b0, MODE_RECOVER);
      add_sample(16'd100,   32'd8400,     1'b1, 1'b0, MODE_RECOVER);
      add_sample(16'd0,     32'd8500,     1'b1, 1'b0, MODE_OTHER);
      add_sample(16'hFFFF,  32'd8600,     1'b1, 1'b0, MODE_OTHER + 3'd1);
      add_sample(16'd0,     32'd8700,     1'b1, 1'b0, MODE_OTHER + 3'd3);
      // Normal entered just before the stamp wraps, then a drop across the wrap.
      add_sample(16'd0,     32'hFFFF_FF00, 1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd0,     32'h0000_02E8, 1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd0,     32'h0000_08C4, 1'b1, 1'b0, MODE_NORMAL);
      add_sample(16'd500,   32'h0000_0900, 1'b0, 1'b1, MODE_OTHER + 3'd2);
      stamp_cursor = 32'h0000_1000;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Moderate settings, no idling.
      run_phase(moderate_settings(), 0, 0, 130);

      // Every register at its top value, sender idling, stamps crossing the wrap.
      s = '1;
      stamp_cursor = 32'hFFFF_0000;
      run_phase(s, 61, 0, 110);

      // Zero bridge speed and zero holds, receiver stalling.
      s = '0;
      s.ddp_enable = 1'b1;
      run_phase(s, 0, 61, 110);

      // Machine disabled: every sample echoes its mode.
      s = moderate_settings();
      s.ddp_enable = 1'b0;
      run_phase(s, 7, 7, 40);

      // Small bridge speed, both sides idling a little.
      s = moderate_settings();
      s.bridge_speed_mmps = HOLD_WIDTH'($urandom_range(40, 1));
      run_phase(s, 7, 7, 130);

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
